FILE: rtl/urzb_pkg.sv
// Shared constants, zone tables and helper functions for the range zone blinker.
package urzb_pkg;

    localparam int FRAC_BITS = 7;
    localparam int ZONES     = 11;

    // Configuration registers
    localparam int CLK_HZ_W   = 28;
    localparam int PRESCALE_W = 8;
    localparam int CFG_W      = CLK_HZ_W;
    localparam int CFG_IDX_W  = 1;
    localparam logic [CFG_IDX_W-1:0] REG_CLOCK_HZ = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESCALE = 1'd1;
    localparam logic [CLK_HZ_W-1:0]   CLK_HZ_RST   = 28'd120000000;
    localparam logic [PRESCALE_W-1:0] PRESCALE_RST = 8'd128;

    // Stream payloads
    localparam int TICKS_W   = 16;
    localparam int S_TDATA_W = 16;
    localparam int ZONE_W    = 4;
    localparam int PERIOD_W  = 11;
    localparam int AVG_W     = 17;
    localparam int M_FIELD_W = ZONE_W + PERIOD_W + 3 + 1 + AVG_W;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;

    // Distance arithmetic
    localparam longint SCALE    = 64'd1000000 << FRAC_BITS;
    localparam int     SCALE_W  = $clog2(SCALE + 1);
    localparam int     PROD_W   = TICKS_W + PRESCALE_W;
    localparam int     NUM_W    = PROD_W + SCALE_W;
    localparam int     SOUND_K  = 58;
    localparam int     DEN_W    = CLK_HZ_W + $clog2(SOUND_K + 1);
    localparam int     DIST_W   = $clog2((400 << FRAC_BITS) + 1);
    localparam int     Q_W      = DIST_W + 1;
    localparam int     WIDE_W   = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;
    localparam int     STEP_W   = $clog2(Q_W + 1);
    localparam logic [DIST_W-1:0] DIST_LO = DIST_W'(2 << FRAC_BITS);
    localparam logic [DIST_W-1:0] DIST_HI = DIST_W'(400 << FRAC_BITS);
    localparam int     SUM_W    = DIST_W + 1;
    localparam int     BND_W    = SUM_W + 1;

    // LED codes
    localparam logic [1:0] LED_RED   = 2'd0;
    localparam logic [1:0] LED_GREEN = 2'd1;
    localparam logic [1:0] LED_BLUE  = 2'd2;

    localparam logic [8:0] LO_CM [ZONES] = '{9'd2, 9'd10, 9'd25, 9'd50, 9'd75, 9'd100,
                                            9'd120, 9'd140, 9'd160, 9'd180, 9'd200};
    localparam logic [8:0] HI_CM [ZONES] = '{9'd10, 9'd25, 9'd50, 9'd75, 9'd100, 9'd120,
                                            9'd140, 9'd160, 9'd180, 9'd200, 9'd401};
    localparam logic [PERIOD_W-1:0] PER_MS [ZONES] = '{11'd0, 11'd400, 11'd600, 11'd800,
                                                      11'd1000, 11'd200, 11'd400, 11'd600,
                                                      11'd800, 11'd1000, 11'd2000};

    // First zone whose bounds strictly enclose the pair sum, else the last zone
    function automatic logic [ZONE_W-1:0] zone_of(input logic [SUM_W-1:0] sum);
        logic [ZONE_W-1:0] z;
        logic              found;
        logic [BND_W-1:0]  a;
        logic [BND_W-1:0]  b;
        logic [BND_W-1:0]  s;
        z     = ZONE_W'(ZONES - 1);
        found = 1'b0;
        s     = BND_W'(sum);
        for (int i = 0; i < ZONES; i++) begin
            a = BND_W'(LO_CM[i]) << (FRAC_BITS + 1);
            b = BND_W'(HI_CM[i]) << (FRAC_BITS + 1);
            if (!found && s > a && s < b) begin
                z     = ZONE_W'(i);
                found = 1'b1;
            end
        end
        return z;
    endfunction

    // Rescale a pair sum to 1/256 cm
    function automatic logic [AVG_W-1:0] avg_of(input logic [SUM_W-1:0] sum);
        logic [31:0] w;
        w = 32'(sum);
        if (FRAC_BITS <= 7) begin
            w = w << (7 - FRAC_BITS);
        end else begin
            w = w >> (FRAC_BITS - 7);
        end
        return w[AVG_W-1:0];
    endfunction

    // LED bit set that a led code selects
    function automatic logic [2:0] led_bit(input logic [1:0] led);
        logic [2:0] b;
        case (led)
            LED_RED:   b = 3'b001;
            LED_GREEN: b = 3'b010;
            LED_BLUE:  b = 3'b100;
            default:   b = 3'b000;
        endcase
        return b;
    endfunction

endpackage

FILE: rtl/urzb_dist.sv
// Distance engine: product, scale and restoring divide with clamp to the sensor range.
module urzb_dist (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [urzb_pkg::TICKS_W-1:0]    i_ticks,
    input  logic [urzb_pkg::PRESCALE_W-1:0] i_prescale,
    input  logic [urzb_pkg::CLK_HZ_W-1:0]   i_clock_hz,
    output logic                            o_done,
    output logic [urzb_pkg::DIST_W-1:0]     o_dist
);
    import urzb_pkg::*;

    localparam logic [2:0] D_IDLE  = 3'd0;
    localparam logic [2:0] D_SCALE = 3'd1;
    localparam logic [2:0] D_DIV   = 3'd2;
    localparam logic [2:0] D_CLAMP = 3'd3;

    logic [2:0]        r_st, n_st;
    logic [PROD_W-1:0] r_prod, n_prod;
    logic [DEN_W-1:0]  r_den, n_den;
    logic [WIDE_W-1:0] r_rem, n_rem;
    logic [WIDE_W-1:0] r_dsh, n_dsh;
    logic [Q_W-1:0]    r_q, n_q;
    logic              r_sat, n_sat;
    logic [STEP_W-1:0] r_cnt, n_cnt;
    logic [DIST_W-1:0] r_dist, n_dist;
    logic              r_done, n_done;
    logic              w_ge;

    // shared compare and subtract unit
    assign w_ge = (r_rem >= r_dsh);

    always_comb begin
        n_st   = r_st;
        n_prod = r_prod;
        n_den  = r_den;
        n_rem  = r_rem;
        n_dsh  = r_dsh;
        n_q    = r_q;
        n_sat  = r_sat;
        n_cnt  = r_cnt;
        n_dist = r_dist;
        n_done = 1'b0;
        case (r_st)
            D_IDLE: begin
                if (i_start) begin
                    n_prod = PROD_W'(i_ticks) * PROD_W'(i_prescale);
                    n_den  = DEN_W'(i_clock_hz) * DEN_W'(SOUND_K);
                    n_st   = D_SCALE;
                end
            end
            D_SCALE: begin
                n_rem = WIDE_W'(NUM_W'(r_prod) * NUM_W'(SCALE));
                n_dsh = WIDE_W'(r_den) << Q_W;
                n_q   = '0;
                n_sat = 1'b0;
                n_cnt = STEP_W'(Q_W);
                n_st  = D_DIV;
            end
            D_DIV: begin
                if (r_cnt == STEP_W'(Q_W)) begin
                    // quotient beyond the clamp range (also a zero divisor)
                    if (w_ge) begin
                        n_sat = 1'b1;
                        n_st  = D_CLAMP;
                    end
                end else begin
                    n_q = {r_q[Q_W-2:0], w_ge};
                    if (w_ge) begin
                        n_rem = r_rem - r_dsh;
                    end
                    if (r_cnt == '0) begin
                        n_st = D_CLAMP;
                    end
                end
                n_dsh = r_dsh >> 1;
                n_cnt = r_cnt - STEP_W'(1);
            end
            D_CLAMP: begin
                if (r_sat || r_q > Q_W'(DIST_HI)) begin
                    n_dist = DIST_HI;
                end else if (r_q < Q_W'(DIST_LO)) begin
                    n_dist = DIST_LO;
                end else begin
                    n_dist = r_q[DIST_W-1:0];
                end
                n_done = 1'b1;
                n_st   = D_IDLE;
            end
            default: begin
                n_st = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= D_IDLE;
            r_done <= 1'b0;
        end else begin
            r_st   <= n_st;
            r_done <= n_done;
        end
        r_prod <= n_prod;
        r_den  <= n_den;
        r_rem  <= n_rem;
        r_dsh  <= n_dsh;
        r_q    <= n_q;
        r_sat  <= n_sat;
        r_cnt  <= n_cnt;
        r_dist <= n_dist;
    end

    assign o_done = r_done;
    assign o_dist = r_dist;

endmodule

FILE: rtl/ultrasonic_range_zone_blinker_unit.sv
// Request flow: an echo request runs through the restoring divider in the distance
// engine (one compare/subtract per cycle) before its result is loaded. A tick request
// goes straight to the result stage. One request is in work at a time; the next is
// accepted in the cycle after its result is loaded, even while that result waits.
// Synchronous active-low reset clears pairing, zone, period, LEDs, tick counter
// and restores clock_hz to 120000000 and prescale to 128.
module ultrasonic_range_zone_blinker_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [urzb_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [urzb_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // echo_ticks[15:0]
    input  logic [urzb_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // kind[0]
    input  logic                             s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // zone[3:0], period_ms[14:4], led_red[15], led_green[16], led_blue[17],
    // pair_done[18], avg_distance[35:19], zero[39:36]
    output logic [urzb_pkg::M_TDATA_W-1:0]   m_axis_tdata
);
    import urzb_pkg::*;

    localparam logic [1:0] T_IDLE = 2'd0;
    localparam logic [1:0] T_DIST = 2'd1;
    localparam logic [1:0] T_FIN  = 2'd2;

    logic [1:0]            r_st, n_st;
    logic [CLK_HZ_W-1:0]   r_clock_hz;
    logic [PRESCALE_W-1:0] r_prescale;
    logic                  r_kind;
    logic                  r_have_first, n_have_first;
    logic [DIST_W-1:0]     r_first, n_first;
    logic [ZONE_W-1:0]     r_zone, n_zone;
    logic                  r_period_valid, n_period_valid;
    logic [PERIOD_W-1:0]   r_period, n_period;
    logic [1:0]            r_led, n_led;
    logic [2:0]            r_lit, n_lit;
    logic [PERIOD_W-1:0]   r_tick, n_tick;
    logic                  r_mvalid, n_mvalid;
    logic [M_TDATA_W-1:0]  r_mdata, n_mdata;

    logic                  w_in_acc;
    logic                  w_out_free;
    logic                  w_dist_done;
    logic [DIST_W-1:0]     w_dist;
    logic [SUM_W-1:0]      w_sum;
    logic [ZONE_W-1:0]     w_z;
    logic [PERIOD_W-1:0]   w_per;
    logic [PERIOD_W-1:0]   w_tick_inc;
    logic                  w_pair;
    logic [AVG_W-1:0]      w_avg;

    assign s_axis_tready = (r_st == T_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_mvalid || m_axis_tready;

    urzb_dist u_dist (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_in_acc && !s_axis_tuser),
        .i_ticks    (s_axis_tdata[TICKS_W-1:0]),
        .i_prescale (r_prescale),
        .i_clock_hz (r_clock_hz),
        .o_done     (w_dist_done),
        .o_dist     (w_dist)
    );

    assign w_sum      = SUM_W'(r_first) + SUM_W'(w_dist);
    assign w_z        = zone_of(w_sum);
    assign w_per      = PER_MS[w_z];
    assign w_tick_inc = r_tick + PERIOD_W'(1);

    always_comb begin
        n_st           = r_st;
        n_have_first   = r_have_first;
        n_first        = r_first;
        n_zone         = r_zone;
        n_period_valid = r_period_valid;
        n_period       = r_period;
        n_led          = r_led;
        n_lit          = r_lit;
        n_tick         = r_tick;
        n_mvalid       = r_mvalid && !m_axis_tready;
        n_mdata        = r_mdata;
        w_pair         = 1'b0;
        w_avg          = '0;
        case (r_st)
            T_IDLE: begin
                if (w_in_acc) begin
                    n_st = s_axis_tuser ? T_FIN : T_DIST;
                end
            end
            T_DIST: begin
                if (w_dist_done) begin
                    n_st = T_FIN;
                end
            end
            T_FIN: begin
                if (w_out_free) begin
                    if (!r_kind) begin
                        if (!r_have_first) begin
                            n_first      = w_dist;
                            n_have_first = 1'b1;
                        end else begin
                            n_have_first = 1'b0;
                            w_pair       = 1'b1;
                            w_avg        = avg_of(w_sum);
                            if (!r_period_valid || w_per != r_period) begin
                                n_period_valid = 1'b1;
                                n_period       = w_per;
                                n_zone         = w_z;
                                if (w_z == ZONE_W'(ZONES - 1)) begin
                                    n_led = LED_GREEN;
                                end else if (w_z inside {[4'd5:4'd9]}) begin
                                    n_led = LED_BLUE;
                                end else begin
                                    n_led = LED_RED;
                                end
                                // all off, then the new LED acts: lit either way
                                n_lit  = led_bit(n_led);
                                n_tick = '0;
                            end
                        end
                    end else if (r_period_valid) begin
                        if (w_tick_inc >= r_period) begin
                            n_tick = '0;
                            n_lit  = (r_zone == '0) ? (r_lit | led_bit(r_led))
                                                    : (r_lit ^ led_bit(r_led));
                        end else begin
                            n_tick = w_tick_inc;
                        end
                    end
                    n_mvalid = 1'b1;
                    n_mdata  = M_TDATA_W'({w_avg, w_pair, n_lit[2], n_lit[1], n_lit[0],
                                           n_period, n_zone});
                    n_st     = T_IDLE;
                end
            end
            default: begin
                n_st = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st           <= T_IDLE;
            r_clock_hz     <= CLK_HZ_RST;
            r_prescale     <= PRESCALE_RST;
            r_have_first   <= 1'b0;
            r_first        <= '0;
            r_zone         <= '0;
            r_period_valid <= 1'b0;
            r_period       <= '0;
            r_led          <= LED_RED;
            r_lit          <= '0;
            r_tick         <= '0;
            r_mvalid       <= 1'b0;
        end else begin
            r_st           <= n_st;
            r_have_first   <= n_have_first;
            r_first        <= n_first;
            r_zone         <= n_zone;
            r_period_valid <= n_period_valid;
            r_period       <= n_period;
            r_led          <= n_led;
            r_lit          <= n_lit;
            r_tick         <= n_tick;
            r_mvalid       <= n_mvalid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_CLOCK_HZ: r_clock_hz <= i_cfg_data[CLK_HZ_W-1:0];
                    REG_PRESCALE: r_prescale <= i_cfg_data[PRESCALE_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
        if (w_in_acc) begin
            r_kind <= s_axis_tuser;
        end
        r_mdata <= n_mdata;
    end

    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata  = r_mdata;

`ifndef SYNTHESIS
    a_lit_onehot0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(r_lit))
        else $error("more than one LED lit");

    a_dark_before_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_period_valid |-> (r_lit == '0 && r_tick == '0))
        else $error("LED or tick activity before any pair");

    a_tick_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_period_valid |-> (r_tick < r_period || r_tick == '0))
        else $error("tick counter ran past the period");

    a_done_in_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_dist_done |-> (r_st == T_DIST))
        else $error("distance result outside of an echo request");
`endif

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the ultrasonic range zone blinker unit.
module tb;
    import urzb_pkg::*;

    localparam logic KIND_ECHO = 1'b0;
    localparam logic KIND_TICK = 1'b1;
    localparam int   SETTLE_CYCLES = 30;

    // Zone bounds in cm and blink periods in ms
    localparam int unsigned ZONE_LO [ZONES] = '{2, 10, 25, 50, 75, 100, 120, 140, 160, 180, 200};
    localparam int unsigned ZONE_HI [ZONES] = '{10, 25, 50, 75, 100, 120, 140, 160, 180, 200, 401};
    localparam int unsigned ZONE_PERIOD [ZONES] =
        '{0, 400, 600, 800, 1000, 200, 400, 600, 800, 1000, 2000};

    typedef struct {
        logic [ZONE_W-1:0]   zone;
        logic [PERIOD_W-1:0] period_ms;
        logic                red;
        logic                green;
        logic                blue;
        logic                pair_done;
        logic [AVG_W-1:0]    avg_dist;
    } t_blink_status;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx = REG_CLOCK_HZ;
    logic [CFG_W-1:0]       i_cfg_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata = '0;
    logic                   s_axis_tuser = KIND_ECHO;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_axis_tdata;

    ultrasonic_range_zone_blinker_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #1 i_clk = ~i_clk;

    // Predicted block state and timer settings
    logic [CLK_HZ_W-1:0]   timer_hz = CLK_HZ_RST;
    logic [PRESCALE_W-1:0] timer_div = PRESCALE_RST;
    logic                  holding_first = 1'b0;
    logic [15:0]           first_range = '0;
    logic [ZONE_W-1:0]     cur_zone = '0;
    logic                  period_set = 1'b0;
    logic [PERIOD_W-1:0]   cur_period = '0;
    logic [1:0]            cur_led = LED_RED;
    logic [2:0]            lit_mask = '0;
    logic [PERIOD_W-1:0]   ms_count = '0;

    t_blink_status expected_status [$];
    int unsigned   mismatches = 0;
    int unsigned   requests_sent = 0;
    logic          quiet = 1'b0;

    // Distance in 1/2^FRAC_BITS cm for an echo width under the current timer settings
    function automatic logic [15:0] range_of(input logic [15:0] ticks);
        longint unsigned num;
        longint unsigned den;
        longint unsigned q;
        den = 64'(timer_hz) * 64'd58;
        if (den == 0) return 16'(400 << FRAC_BITS);
        num = (64'(ticks) * 64'(timer_div) * 64'd1000000) << FRAC_BITS;
        q = num / den;
        if (q < (2 << FRAC_BITS)) q = 2 << FRAC_BITS;
        if (q > (400 << FRAC_BITS)) q = 400 << FRAC_BITS;
        return q[15:0];
    endfunction

    function automatic void advance_led();
        logic [2:0] bit_sel;
        bit_sel = 3'b001 << cur_led;
        if (cur_zone == 0) lit_mask = lit_mask | bit_sel;
        else lit_mask = lit_mask ^ bit_sel;
    endfunction

    function automatic void predict_status(input logic kind, input logic [15:0] ticks);
        t_blink_status st;
        logic [15:0]   d;
        int unsigned   pair_sum;
        int unsigned   z;
        logic          found;
        st.pair_done = 1'b0;
        st.avg_dist  = '0;
        if (kind == KIND_ECHO) begin
            d = range_of(ticks);
            if (!holding_first) begin
                first_range   = d;
                holding_first = 1'b1;
            end else begin
                pair_sum      = int'(first_range) + int'(d);
                holding_first = 1'b0;
                st.pair_done  = 1'b1;
                st.avg_dist   = AVG_W'((pair_sum << 7) >> FRAC_BITS);
                z     = ZONES - 1;
                found = 1'b0;
                for (int i = 0; i < ZONES; i++) begin
                    if (!found && pair_sum > (ZONE_LO[i] << (FRAC_BITS + 1))
                            && pair_sum < (ZONE_HI[i] << (FRAC_BITS + 1))) begin
                        z     = i;
                        found = 1'b1;
                    end
                end
                // Same period keeps zone and LED as they are
                if (!period_set || ZONE_PERIOD[z] != cur_period) begin
                    period_set = 1'b1;
                    cur_period = PERIOD_W'(ZONE_PERIOD[z]);
                    cur_zone   = ZONE_W'(z);
                    if (z == ZONES - 1) cur_led = LED_GREEN;
                    else if (z >= 5 && z <= 9) cur_led = LED_BLUE;
                    else cur_led = LED_RED;
                    lit_mask = '0;
                    advance_led();
                    ms_count = '0;
                end
            end
        end else if (period_set) begin
            ms_count = ms_count + 1'b1;
            if (ms_count >= cur_period) begin
                ms_count = '0;
                advance_led();
            end
        end
        st.zone      = cur_zone;
        st.period_ms = cur_period;
        st.red       = lit_mask[0];
        st.green     = lit_mask[1];
        st.blue      = lit_mask[2];
        expected_status.push_back(st);
    endfunction

    // Echo width that lands at or just above a distance given in 1/2^FRAC_BITS cm
    function automatic logic [15:0] ticks_for(input int unsigned dq);
        longint unsigned num;
        longint unsigned den;
        longint unsigned t;
        if (timer_hz == 0 || timer_div == 0) return 16'($urandom_range(0, 65535));
        num = 64'(dq) * 64'd58 * 64'(timer_hz);
        den = (64'(timer_div) * 64'd1000000) << FRAC_BITS;
        t = (num + den - 1) / den;
        if (t > 65535) t = 65535;
        return t[15:0];
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch in %s: expected %0d, got %0d", name, want, got);
        end
    endfunction

    always @(negedge i_clk) m_axis_tready <= quiet || ($urandom_range(99) >= 23);

    always @(posedge i_clk) begin : check_results
        t_blink_status want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_status.size() == 0) begin
                check_field("unexpected result", 0, 1);
            end else begin
                want = expected_status.pop_front();
                check_field("zone", want.zone, m_axis_tdata[3:0]);
                check_field("period_ms", want.period_ms, m_axis_tdata[14:4]);
                check_field("led_red", want.red, m_axis_tdata[15]);
                check_field("led_green", want.green, m_axis_tdata[16]);
                check_field("led_blue", want.blue, m_axis_tdata[17]);
                check_field("pair_done", want.pair_done, m_axis_tdata[18]);
                check_field("avg_distance", want.avg_dist, m_axis_tdata[35:19]);
            end
        end
    end

    task automatic send_request(input logic kind, input logic [15:0] ticks);
        if (!quiet && $urandom_range(99) < 23) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= ticks;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_status(kind, ticks);
        requests_sent++;
        @(negedge i_clk);
    endtask

    // Drop valid and hold until every result is back and the block is quiet
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (expected_status.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic settle_and_configure(input logic [CLK_HZ_W-1:0] hz,
                                        input logic [PRESCALE_W-1:0] div);
        drain_results();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_CLOCK_HZ;
        i_cfg_data <= CFG_W'(hz);
        @(negedge i_clk);
        i_cfg_idx  <= REG_PRESCALE;
        i_cfg_data <= CFG_W'(div);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        timer_hz  = hz;
        timer_div = div;
        @(negedge i_clk);
    endtask

    task automatic send_pair_in_zone(input int unsigned z);
        int unsigned lo;
        int unsigned hi;
        lo = (ZONE_LO[z] << FRAC_BITS) + 1;
        hi = (z == ZONES - 1) ? (400 << FRAC_BITS) : (ZONE_HI[z] << FRAC_BITS) - 1;
        send_request(KIND_ECHO, ticks_for($urandom_range(lo, hi)));
        send_request(KIND_ECHO, ticks_for($urandom_range(lo, hi)));
    endtask

    task automatic test_zone_walk();
        // Tick before any measurement is ignored
        send_request(KIND_TICK, 16'hFFFF);
        // Both echoes clamp to 2 cm: the sum sits on the zone 0 bound, so last zone
        send_request(KIND_ECHO, 16'h0000);
        send_request(KIND_ECHO, 16'h0000);
        // Both saturate to 400 cm: still the last zone, nothing changes
        send_request(KIND_ECHO, 16'hFFFF);
        send_request(KIND_ECHO, 16'hFFFF);
        // Steady zone: every tick relights red
        send_pair_in_zone(0);
        send_request(KIND_TICK, 16'h0000);
        send_request(KIND_TICK, 16'h5A5A);
        send_pair_in_zone(5);
        send_request(KIND_TICK, 16'h0001);
        // Zone 6 has the same period as zone 1, so zone 1 stays
        send_pair_in_zone(1);
        send_pair_in_zone(6);
        send_request(KIND_TICK, 16'h8000);
    endtask

    task automatic test_config_extremes();
        settle_and_configure('0, PRESCALE_RST);
        send_request(KIND_ECHO, 16'd1);
        send_request(KIND_ECHO, 16'd30000);
        settle_and_configure(CLK_HZ_RST, '0);
        send_request(KIND_ECHO, 16'hFFFF);
        send_request(KIND_ECHO, 16'd1234);
        settle_and_configure('1, '1);
        send_pair_in_zone(0);
        send_request(KIND_TICK, 16'd7);
    endtask

    task automatic test_random_traffic(input logic [CLK_HZ_W-1:0] hz,
                                       input logic [PRESCALE_W-1:0] div,
                                       input int unsigned count, input logic calm);
        int unsigned start;
        int unsigned pick;
        int unsigned run;
        settle_and_configure(hz, div);
        quiet = calm;
        start = requests_sent;
        while (requests_sent - start < count) begin
            pick = $urandom_range(99);
            if (pick < 65) begin
                // Close a dangling echo so the pair lines up
                if (holding_first) send_request(KIND_ECHO, 16'($urandom_range(0, 65535)));
                send_pair_in_zone($urandom_range(0, ZONES - 1));
                if (cur_period <= 450 && $urandom_range(7) == 0)
                    run = cur_period + $urandom_range(1, 6);
                else
                    run = $urandom_range(0, 12);
                repeat (run) send_request(KIND_TICK, 16'($urandom_range(0, 65535)));
            end else if (pick < 80) begin
                send_request(KIND_ECHO, 16'($urandom_range(0, 65535)));
            end else begin
                repeat ($urandom_range(1, 6))
                    send_request(1'($urandom_range(1)), 16'($urandom_range(0, 65535)));
            end
        end
        quiet = 1'b0;
    endtask

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_zone_walk();
        test_config_extremes();
        test_random_traffic(28'd120000000, 8'd128, 300, 1'b1);
        test_random_traffic(28'd48000000, 8'd64, 260, 1'b0);
        test_random_traffic(28'd200000000, 8'd128, 260, 1'b0);
        test_random_traffic(28'd16000000, 8'd8, 200, 1'b0);
        test_random_traffic('1, '1, 60, 1'b0);
        test_random_traffic(28'd1, 8'd1, 40, 1'b0);
        drain_results();
        if (mismatches == 0 && expected_status.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

FILE: sim.f
rtl/urzb_pkg.sv
rtl/urzb_dist.sv
rtl/ultrasonic_range_zone_blinker_unit.sv
tb/tb.sv
